FILE: design/assert_macros.svh
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/cst_pkg.sv
package cst_pkg;

   localparam int unsigned DataBytesDefault   = 65536;
   localparam int unsigned SourceBytesDefault = 65536;
   localparam logic [31:0] DataBaseReset      = 32'h0001_0000;
   localparam int unsigned MaxResults         = 3;

   // Token codes.
   localparam logic [7:0] TK_NUM    = 8'd128;
   localparam logic [7:0] TK_ID     = 8'd129;
   localparam logic [7:0] TK_STR    = 8'd130;
   localparam logic [7:0] TK_KW0    = 8'd131;
   localparam logic [7:0] TK_BECOMES = 8'd140;
   localparam logic [7:0] TK_LOR    = 8'd142;
   localparam logic [7:0] TK_LAND   = 8'd143;
   localparam logic [7:0] TK_EQ     = 8'd147;
   localparam logic [7:0] TK_NE     = 8'd148;
   localparam logic [7:0] TK_LT     = 8'd149;
   localparam logic [7:0] TK_GT     = 8'd150;
   localparam logic [7:0] TK_LE     = 8'd151;
   localparam logic [7:0] TK_GE     = 8'd152;
   localparam logic [7:0] TK_SHL    = 8'd153;
   localparam logic [7:0] TK_SHR    = 8'd154;
   localparam logic [7:0] TK_ADD    = 8'd155;
   localparam logic [7:0] TK_SUB    = 8'd156;
   localparam logic [7:0] TK_MUL    = 8'd157;
   localparam logic [7:0] TK_DIV    = 8'd158;
   localparam logic [7:0] TK_MOD    = 8'd159;
   localparam logic [7:0] TK_INC    = 8'd160;
   localparam logic [7:0] TK_DEC    = 8'd161;
   localparam logic [7:0] TK_BRAK   = 8'd162;
   localparam logic [7:0] TK_EOF    = 8'd199;

   localparam logic ITEM_TOKEN = 1'b0;
   localparam logic ITEM_DATA  = 1'b1;

   // One result word.
   typedef struct packed {
      logic        item_kind;
      logic [7:0]  token_code;
      logic [31:0] token_value;
      logic [15:0] ident_start;
      logic [15:0] ident_length;
      logic [15:0] line_number;
      logic [15:0] data_address;
      logic [7:0]  data_byte;
      logic        last;
   } result_type;

   // A scanned character as handed from the front to the back.
   typedef struct packed {
      logic [7:0]  ch;
      logic        is_digit;
      logic        is_alpha;
      logic        is_hex;
      logic [3:0]  hex_value;
      logic        is_blank;
      logic        is_op1;
   } class_type;

   localparam int unsigned KwCount = 8;

   function automatic logic [47:0] kw_bits(input logic [2:0] i);
      logic [47:0] r;
      unique case (i)
         3'd0: r = 48'h696E74;
         3'd1: r = 48'h63686172;
         3'd2: r = 48'h656E756D;
         3'd3: r = 48'h6966;
         3'd4: r = 48'h656C7365;
         3'd5: r = 48'h7768696C65;
         3'd6: r = 48'h72657475726E;
         default: r = 48'h73697A656F66;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] kw_len(input logic [2:0] i);
      logic [2:0] r;
      unique case (i)
         3'd0: r = 3'd3;
         3'd1, 3'd2, 3'd4: r = 3'd4;
         3'd3: r = 3'd2;
         3'd5: r = 3'd5;
         default: r = 3'd6;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] escape_char(input logic [7:0] c);
      logic [7:0] r;
      if (c == "n") r = 8'd10;
      else if (c == "t") r = 8'd9;
      else if (c == "0") r = 8'd0;
      else r = c;
      return r;
   endfunction

endpackage

FILE: design/c_subset_tokenizer.sv
// Channel   Direction  Handshake              Payload
// req       in         push / full            ch
// rsp       out        empty / pop            item_kind .. last
// csr       in         csr_valid / csr_ready  string base address (32 bits)
// One character is taken per cycle; the scanner state machine in the back
// stage advances once per character and writes up to three results into the
// output queue in the same cycle. Input stalls only when that queue lacks
// room for three more words and the stage register is occupied.
// Reset is synchronous and active high; a character is registered in the front
// stage, and its results enter the output queue when the back stage takes it.
module c_subset_tokenizer #(
   parameter int unsigned DATA_BYTES   = cst_pkg::DataBytesDefault,
   parameter int unsigned SOURCE_BYTES = cst_pkg::SourceBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_ch,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_token_code,
   output logic [31:0] rsp_token_value,
   output logic [15:0] rsp_ident_start,
   output logic [15:0] rsp_ident_length,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_data_address,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data_base
);
   import cst_pkg::*;

   logic [31:0] base_ff;
   logic        fq_valid, fq_ready, space;
   class_type   fq_class;
   logic [1:0]  rcount;
   result_type  r0, r1, r2, head;

   // The base register is always writable; the user must write it only while idle, as the block does not enforce this.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= DataBaseReset;
      end else if (csr_valid) begin
         base_ff <= csr_data_base;
      end
   end

   cst_front u_front (
      .clock, .reset, .in_push(push), .in_ch(req_ch), .in_full(full),
      .out_valid(fq_valid), .out_class(fq_class), .out_ready(fq_ready)
   );

   cst_back #(.DATA_BYTES(DATA_BYTES), .SOURCE_BYTES(SOURCE_BYTES)) u_back (
      .clock, .reset, .str_base(base_ff), .in_valid(fq_valid), .in_class(fq_class),
      .in_ready(fq_ready), .res_count(rcount), .res0(r0), .res1(r1), .res2(r2),
      .res_space(space)
   );

   cst_outq u_outq (
      .clock, .reset, .wr_count(rcount), .wr0(r0), .wr1(r1), .wr2(r2),
      .has_space(space), .empty, .head, .pop
   );

   assign rsp_item_kind    = head.item_kind;
   assign rsp_token_code   = head.token_code;
   assign rsp_token_value  = head.token_value;
   assign rsp_ident_start  = head.ident_start;
   assign rsp_ident_length = head.ident_length;
   assign rsp_line_number  = head.line_number;
   assign rsp_data_address = head.data_address;
   assign rsp_data_byte    = head.data_byte;
   assign rsp_last         = head.last;

`include "assert_macros.svh"
   `ASSERT_NEXT(a_csr_written, clock, reset, csr_valid && csr_ready, base_ff == $past(csr_data_base))
endmodule

FILE: design/cst_front.sv
module cst_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_push,
   input  logic [7:0]            in_ch,
   output logic                  in_full,
   output logic                  out_valid,
   output cst_pkg::class_type    out_class,
   input  logic                  out_ready
);
   import cst_pkg::*;

   logic      valid_ff, valid_in;
   class_type class_ff, class_in;
   logic [7:0] c;

   assign c = in_ch;
   assign in_full = valid_ff && !out_ready;

   always_comb begin
      class_in.ch       = c;
      class_in.is_digit = (c >= "0") && (c <= "9");
      class_in.is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
                          || (c == "_");
      class_in.is_hex   = 1'b1;
      class_in.hex_value = 4'd0;
      if (class_in.is_digit) class_in.hex_value = 4'(c - "0");
      else if ((c >= "a") && (c <= "f")) class_in.hex_value = 4'(c - "a" + 8'd10);
      else if ((c >= "A") && (c <= "F")) class_in.hex_value = 4'(c - "A" + 8'd10);
      else class_in.is_hex = 1'b0;
      class_in.is_blank = (c == " ") || (c == 8'd9) || (c == 8'd13);
      class_in.is_op1   = (c == "=") || (c == "!") || (c == "<") || (c == ">") ||
                          (c == "|") || (c == "&") || (c == "+") || (c == "-");
      valid_in = valid_ff;
      if (out_ready) valid_in = 1'b0;
      if (in_push && !in_full) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_push && !in_full) class_ff <= class_in;
   end

   assign out_valid = valid_ff;
   assign out_class = class_ff;
endmodule

FILE: design/cst_back.sv
module cst_back #(
   parameter int unsigned DATA_BYTES   = cst_pkg::DataBytesDefault,
   parameter int unsigned SOURCE_BYTES = cst_pkg::SourceBytesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           str_base,
   input  logic                  in_valid,
   input  cst_pkg::class_type    in_class,
   output logic                  in_ready,
   output logic [1:0]            res_count,
   output cst_pkg::result_type   res0,
   output cst_pkg::result_type   res1,
   output cst_pkg::result_type   res2,
   input  logic                  res_space
);
   import cst_pkg::*;

   typedef enum logic [4:0] {
      MD_IDLE, MD_SLASH, MD_LINEC, MD_BLOCK, MD_BLOCKSTAR, MD_ZERO, MD_DEC,
      MD_HEX, MD_IDENT, MD_STR, MD_STRESC, MD_CHQ, MD_CHESC, MD_CHCLOSE,
      MD_OP1, MD_DONE
   } mode_type;

   localparam int unsigned SrcW  = $clog2(SOURCE_BYTES);
   localparam int unsigned DataW = $clog2(DATA_BYTES);

   mode_type         mode_ff, mode_in;
   logic [SrcW-1:0]  pos_ff, pos_in;
   logic [15:0]      line_ff, line_in;
   logic [31:0]      acc_ff, acc_in;
   logic [15:0]      start_ff, start_in;
   logic [15:0]      len_ff, len_in;
   logic [47:0]      kw_ff, kw_in;
   logic [DataW-1:0] wptr_ff, wptr_in;
   logic [DataW-1:0] wptr_next;

   result_type r [MaxResults];
   logic [1:0] n;
   logic       fire;
   logic [7:0] c;
   logic       redo;
   logic [7:0] icode;

   assign in_ready = res_space;
   assign fire = in_valid && res_space;
   assign c = in_class.ch;

   // The string store pointer wraps at the store size.
   assign wptr_next = (wptr_ff == DataW'(DATA_BYTES - 1)) ? '0 : wptr_ff + 1'b1;

   function automatic result_type mk(input logic kind, input logic [7:0] code,
                                     input logic [31:0] val, input logic [15:0] ln);
      result_type t;
      t = '0;
      t.item_kind = kind;
      t.token_code = code;
      t.token_value = val;
      t.line_number = ln;
      return t;
   endfunction

   always_comb begin
      mode_in = mode_ff; pos_in = pos_ff; line_in = line_ff; acc_in = acc_ff;
      start_in = start_ff; len_in = len_ff; kw_in = kw_ff; wptr_in = wptr_ff;
      n = 2'd0; redo = 1'b0;
      icode = TK_ID;
      for (int k = 0; k < MaxResults; k++) r[k] = '0;
      for (int k = KwCount - 1; k >= 0; k--)
         if (len_ff == 16'(kw_len(3'(k))) && kw_ff == kw_bits(3'(k)))
            icode = TK_KW0 + 8'(k);

      unique case (mode_ff)
         MD_SLASH: begin
            if (c == "/") mode_in = MD_LINEC;
            else if (c == "*") mode_in = MD_BLOCK;
            else begin r[0] = mk(ITEM_TOKEN, TK_DIV, '0, line_ff); n = 2'd1; redo = 1'b1; end
         end
         MD_LINEC: redo = (c == 8'd0) || (c == 8'd10);
         MD_BLOCK, MD_BLOCKSTAR: begin
            if (c == 8'd0) redo = 1'b1;
            else if (mode_ff == MD_BLOCKSTAR && c == "/") mode_in = MD_IDLE;
            else begin
               if (c == 8'd10 && line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
               mode_in = (c == "*") ? MD_BLOCKSTAR : MD_BLOCK;
            end
         end
         MD_ZERO, MD_DEC: begin
            if (mode_ff == MD_ZERO && (c == "x" || c == "X")) begin
               acc_in = '0; mode_in = MD_HEX;
            end else if (in_class.is_digit) begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + 32'(in_class.hex_value);
               mode_in = MD_DEC;
            end else begin
               r[0] = mk(ITEM_TOKEN, TK_NUM, acc_ff, line_ff); n = 2'd1; redo = 1'b1;
            end
         end
         MD_HEX: begin
            if (in_class.is_hex) acc_in = {acc_ff[27:0], in_class.hex_value};
            else begin r[0] = mk(ITEM_TOKEN, TK_NUM, acc_ff, line_ff); n = 2'd1; redo = 1'b1; end
         end
         MD_IDENT: begin
            if (in_class.is_alpha || in_class.is_digit) begin
               if (len_ff < 16'd6) kw_in = {kw_ff[39:0], c};
               if (len_ff != 16'hFFFF) len_in = len_ff + 16'd1;
            end else begin
               r[0] = mk(ITEM_TOKEN, icode, '0, line_ff);
               r[0].ident_start = start_ff;
               r[0].ident_length = len_ff;
               n = 2'd1; redo = 1'b1;
            end
         end
         MD_STR, MD_STRESC: begin
            if (c == 8'd0 || (mode_ff == MD_STR && c == "\"")) begin
               r[0] = mk(ITEM_DATA, 8'd0, '0, line_ff);
               r[0].data_address = 16'(wptr_ff);
               r[1] = mk(ITEM_TOKEN, TK_STR, acc_ff, line_ff);
               n = 2'd2;
               wptr_in = wptr_next;
               if (c == 8'd0) redo = 1'b1; else mode_in = MD_IDLE;
            end else if (mode_ff == MD_STR && c == "\\") begin
               mode_in = MD_STRESC;
            end else begin
               r[0] = mk(ITEM_DATA, 8'd0, '0, line_ff);
               r[0].data_address = 16'(wptr_ff);
               r[0].data_byte = (mode_ff == MD_STRESC) ? escape_char(c) : c;
               n = 2'd1;
               wptr_in = wptr_next;
               mode_in = MD_STR;
            end
         end
         MD_CHQ, MD_CHESC: begin
            if (c == 8'd0) begin
               r[0] = mk(ITEM_TOKEN, TK_NUM, '0, line_ff); n = 2'd1; redo = 1'b1;
            end else if (mode_ff == MD_CHQ && c == "\\") mode_in = MD_CHESC;
            else begin
               acc_in = 32'((mode_ff == MD_CHESC) ? escape_char(c) : c);
               mode_in = MD_CHCLOSE;
            end
         end
         MD_CHCLOSE: begin
            r[0] = mk(ITEM_TOKEN, TK_NUM, acc_ff, line_ff); n = 2'd1;
            if (c == "'") mode_in = MD_IDLE; else redo = 1'b1;
         end
         MD_OP1: begin
            logic [7:0] code;
            logic       used;
            code = TK_SUB; used = 1'b0;
            unique case (acc_ff[7:0])
               "=": if (c == "=") begin code = TK_EQ; used = 1'b1; end else code = TK_BECOMES;
               "!": if (c == "=") begin code = TK_NE; used = 1'b1; end else code = "!";
               "<": if (c == "=") begin code = TK_LE; used = 1'b1; end
                    else if (c == "<") begin code = TK_SHL; used = 1'b1; end
                    else code = TK_LT;
               ">": if (c == "=") begin code = TK_GE; used = 1'b1; end
                    else if (c == ">") begin code = TK_SHR; used = 1'b1; end
                    else code = TK_GT;
               "|": if (c == "|") begin code = TK_LOR; used = 1'b1; end else code = "|";
               "&": if (c == "&") begin code = TK_LAND; used = 1'b1; end else code = "&";
               "+": if (c == "+") begin code = TK_INC; used = 1'b1; end else code = TK_ADD;
               default: if (c == "-") begin code = TK_DEC; used = 1'b1; end else code = TK_SUB;
            endcase
            r[0] = mk(ITEM_TOKEN, code, '0, line_ff); n = 2'd1;
            if (used) mode_in = MD_IDLE; else redo = 1'b1;
         end
         MD_DONE: begin
            r[0] = mk(ITEM_TOKEN, TK_EOF, '0, line_ff); n = 2'd1;
         end
         default: redo = 1'b1;
      endcase

      if (redo) begin
         // Dispatch the character again from between tokens; line_in may have moved.
         mode_in = MD_IDLE;
         if (c == 8'd0) begin
            r[n] = mk(ITEM_TOKEN, TK_EOF, '0, line_in); n = n + 2'd1; mode_in = MD_DONE;
         end else if (c == 8'd10) begin
            if (line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
         end else if (in_class.is_blank) begin
         end else if (c == "/") mode_in = MD_SLASH;
         else if (c == "0") begin acc_in = '0; mode_in = MD_ZERO; end
         else if (in_class.is_digit) begin
            acc_in = 32'(in_class.hex_value); mode_in = MD_DEC;
         end else if (in_class.is_alpha) begin
            start_in = 16'(pos_ff); len_in = 16'd1; kw_in = 48'(c); mode_in = MD_IDENT;
         end else if (c == "\"") begin
            acc_in = str_base + 32'(wptr_ff); mode_in = MD_STR;
         end else if (c == "'") mode_in = MD_CHQ;
         else if (in_class.is_op1) begin acc_in = 32'(c); mode_in = MD_OP1; end
         else begin
            logic [7:0] code;
            if (c == "*") code = TK_MUL;
            else if (c == "%") code = TK_MOD;
            else if (c == "[") code = TK_BRAK;
            else code = c;
            r[n] = mk(ITEM_TOKEN, code, '0, line_in); n = n + 2'd1;
         end
      end

      if (c != 8'd0 && mode_in != MD_DONE)
         pos_in = (pos_ff == SrcW'(SOURCE_BYTES - 1)) ? '0 : pos_ff + 1'b1;
      if (n != 2'd0) r[n - 2'd1].last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MD_IDLE; pos_ff <= '0; line_ff <= 16'd1; acc_ff <= '0;
         start_ff <= '0; len_ff <= '0; kw_ff <= '0; wptr_ff <= '0;
      end else if (fire) begin
         mode_ff <= mode_in; pos_ff <= pos_in; line_ff <= line_in; acc_ff <= acc_in;
         start_ff <= start_in; len_ff <= len_in; kw_ff <= kw_in; wptr_ff <= wptr_in;
      end
   end

   assign res_count = fire ? n : 2'd0;
   assign res0 = r[0];
   assign res1 = r[1];
   assign res2 = r[2];

`include "assert_macros.svh"
   `ASSERT_NEXT(a_done_sticks, clock, reset, mode_ff == MD_DONE, mode_ff == MD_DONE)
   `ASSERT_IMPLIES(a_line_nonzero, clock, reset, 1'b1, line_ff != 16'd0)
   `ASSERT_IMPLIES(a_done_emits, clock, reset, fire && mode_ff == MD_DONE, res_count == 2'd1)
endmodule

FILE: design/cst_outq.sv
module cst_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           wr_count,
   input  cst_pkg::result_type  wr0,
   input  cst_pkg::result_type  wr1,
   input  cst_pkg::result_type  wr2,
   output logic                 has_space,
   output logic                 empty,
   output cst_pkg::result_type  head,
   input  logic                 pop
);
   import cst_pkg::*;

   localparam int unsigned Depth = 8;

   result_type mem_ff [Depth];
   logic [2:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign empty = (cnt_ff == 4'd0);
   assign do_pop = pop && !empty;
   assign has_space = (cnt_ff <= 4'(Depth - MaxResults));
   assign head = mem_ff[rd_ff];

   always_comb begin
      rd_in = rd_ff + 3'(do_pop);
      wr_in = wr_ff + 3'(wr_count);
      cnt_in = cnt_ff + 4'(wr_count) - 4'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
      if (wr_count > 2'd0) mem_ff[wr_ff] <= wr0;
      if (wr_count > 2'd1) mem_ff[wr_ff + 3'd1] <= wr1;
      if (wr_count > 2'd2) mem_ff[wr_ff + 3'd2] <= wr2;
   end

`include "assert_macros.svh"
   `ASSERT_IMPLIES(a_no_overflow, clock, reset, 1'b1, cnt_ff <= 4'(Depth))
   `ASSERT_IMPLIES(a_write_has_room, clock, reset, wr_count != 2'd0, has_space)
endmodule
